@@ rtl/des_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package des_pkg;

	localparam int unsigned Rounds = 16;

	typedef logic [63:0] blk_t;
	typedef logic [27:0] half_key_t;
	typedef logic [31:0] half_blk_t;
	typedef logic [47:0] sub_key_t;

	typedef logic [6:0] pos_t;

	localparam pos_t TabIp [64] = '{
		7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,7'd10,7'd2,
		7'd60,7'd52,7'd44,7'd36,7'd28,7'd20,7'd12,7'd4,
		7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,7'd14,7'd6,
		7'd64,7'd56,7'd48,7'd40,7'd32,7'd24,7'd16,7'd8,
		7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,
		7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,
		7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5,
		7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7};

	localparam pos_t TabFp [64] = '{
		7'd40,7'd8,7'd48,7'd16,7'd56,7'd24,7'd64,7'd32,
		7'd39,7'd7,7'd47,7'd15,7'd55,7'd23,7'd63,7'd31,
		7'd38,7'd6,7'd46,7'd14,7'd54,7'd22,7'd62,7'd30,
		7'd37,7'd5,7'd45,7'd13,7'd53,7'd21,7'd61,7'd29,
		7'd36,7'd4,7'd44,7'd12,7'd52,7'd20,7'd60,7'd28,
		7'd35,7'd3,7'd43,7'd11,7'd51,7'd19,7'd59,7'd27,
		7'd34,7'd2,7'd42,7'd10,7'd50,7'd18,7'd58,7'd26,
		7'd33,7'd1,7'd41,7'd9,7'd49,7'd17,7'd57,7'd25};

	localparam pos_t TabPc1 [56] = '{
		7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,
		7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,7'd10,7'd2,
		7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,
		7'd60,7'd52,7'd44,7'd36,7'd63,7'd55,7'd47,7'd39,
		7'd31,7'd23,7'd15,7'd7,7'd62,7'd54,7'd46,7'd38,
		7'd30,7'd22,7'd14,7'd6,7'd61,7'd53,7'd45,7'd37,
		7'd29,7'd21,7'd13,7'd5,7'd28,7'd20,7'd12,7'd4};

	localparam pos_t TabPc2 [48] = '{
		7'd14,7'd17,7'd11,7'd24,7'd1,7'd5,7'd3,7'd28,
		7'd15,7'd6,7'd21,7'd10,7'd23,7'd19,7'd12,7'd4,
		7'd26,7'd8,7'd16,7'd7,7'd27,7'd20,7'd13,7'd2,
		7'd41,7'd52,7'd31,7'd37,7'd47,7'd55,7'd30,7'd40,
		7'd51,7'd45,7'd33,7'd48,7'd44,7'd49,7'd39,7'd56,
		7'd34,7'd53,7'd46,7'd42,7'd50,7'd36,7'd29,7'd32};

	localparam pos_t TabE [48] = '{
		7'd32,7'd1,7'd2,7'd3,7'd4,7'd5,7'd4,7'd5,7'd6,7'd7,7'd8,7'd9,
		7'd8,7'd9,7'd10,7'd11,7'd12,7'd13,7'd12,7'd13,7'd14,7'd15,7'd16,7'd17,
		7'd16,7'd17,7'd18,7'd19,7'd20,7'd21,7'd20,7'd21,7'd22,7'd23,7'd24,7'd25,
		7'd24,7'd25,7'd26,7'd27,7'd28,7'd29,7'd28,7'd29,7'd30,7'd31,7'd32,7'd1};

	localparam pos_t TabP [32] = '{
		7'd16,7'd7,7'd20,7'd21,7'd29,7'd12,7'd28,7'd17,
		7'd1,7'd15,7'd23,7'd26,7'd5,7'd18,7'd31,7'd10,
		7'd2,7'd8,7'd24,7'd14,7'd32,7'd27,7'd3,7'd9,
		7'd19,7'd13,7'd30,7'd6,7'd22,7'd11,7'd4,7'd25};

	localparam logic [15:0] RotTwo = 16'b0011_1111_0111_1110;

	typedef logic [3:0] nib_t;
	localparam nib_t TabS [8][64] = '{
		'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
		4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
		4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
		4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
		'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
		4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
		4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
		4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
		'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
		4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
		4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
		4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
		'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
		4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
		4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
		4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
		'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
		4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
		4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
		4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
		'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
		4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
		4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
		4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
		'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
		4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
		4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
		4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
		'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
		4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
		4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
		4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

	// Gather bits; table positions count from 1 at the MSB.
	function automatic blk_t perm_ip(input blk_t v);
		blk_t r;
		for (int i = 0; i < 64; i++) r[63-i] = v[6'(7'd64 - TabIp[i])];
		return r;
	endfunction

	function automatic blk_t perm_fp(input blk_t v);
		blk_t r;
		for (int i = 0; i < 64; i++) r[63-i] = v[6'(7'd64 - TabFp[i])];
		return r;
	endfunction

	function automatic logic [55:0] perm_pc1(input blk_t v);
		logic [55:0] r;
		for (int i = 0; i < 56; i++) r[55-i] = v[6'(7'd64 - TabPc1[i])];
		return r;
	endfunction

	function automatic sub_key_t perm_pc2(input logic [55:0] v);
		sub_key_t r;
		for (int i = 0; i < 48; i++) r[47-i] = v[6'(7'd56 - TabPc2[i])];
		return r;
	endfunction

	function automatic half_blk_t feistel(input half_blk_t r, input sub_key_t k);
		sub_key_t x;
		half_blk_t s;
		half_blk_t p;
		logic [5:0] b;
		for (int i = 0; i < 48; i++) x[47-i] = r[5'(7'd32 - TabE[i])];
		x = x ^ k;
		for (int j = 0; j < 8; j++) begin
			b = x[47-6*j -: 6];
			s[31-4*j -: 4] = TabS[j][{b[5], b[0], b[4:1]}];
		end
		for (int i = 0; i < 32; i++) p[31-i] = s[5'(7'd32 - TabP[i])];
		return p;
	endfunction

	function automatic half_key_t rotl28(input half_key_t v, input logic two);
		return two ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
	endfunction

endpackage
`default_nettype wire

@@ rtl/des_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface des_stream_if;
	logic valid;
	logic ready;
	logic [63:0] plain_block;
	logic [63:0] cipher_key;
	logic [63:0] cipher_block;
	modport source (output valid, plain_block, cipher_key, cipher_block, input ready);
	modport sink (input valid, plain_block, cipher_key, cipher_block, output ready);
endinterface
`default_nettype wire

@@ rtl/des_block_encrypt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: the entry IP/PC-1 register loads at the accepting edge, then sixteen round
// stages and the FP output stage register the word in turn up to output valid.
// Throughput: one word per cycle; the whole pipe advances when the output is
// empty or taken, so a stall holds every stage.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
module des_block_encrypt (
	input wire logic clk,
	input wire logic arst_n,
	des_stream_if.sink in_ch,
	des_stream_if.source out_ch
);
	import des_pkg::*;

	localparam int unsigned Stages = Rounds + 1;

	// Global advance: move when the output register is free or drained.
	logic adv;
	assign adv = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;

	// Entry stage: initial permutation and key parity drop.
	logic vld_s0;
	half_blk_t l_s0, r_s0;
	half_key_t c_s0, d_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (adv) begin
			vld_s0 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			{l_s0, r_s0} <= perm_ip(in_ch.plain_block);
			{c_s0, d_s0} <= perm_pc1(in_ch.cipher_key);
		end
	end

	// Round chain: index 0 is the entry stage, index n is after round n.
	logic      vld [Stages];
	half_blk_t lh [Stages];
	half_blk_t rh [Stages];
	half_key_t ch [Stages];
	half_key_t dh [Stages];

	assign vld[0] = vld_s0;
	assign lh[0] = l_s0;
	assign rh[0] = r_s0;
	assign ch[0] = c_s0;
	assign dh[0] = d_s0;

	for (genvar g = 0; g < Rounds; g++) begin : g_rnd
		des_round #(.RoundIdx(g)) u_round (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.vld(vld[g]), .l(lh[g]), .r(rh[g]), .c(ch[g]), .d(dh[g]),
			.vld_s1(vld[g+1]), .l_s1(lh[g+1]), .r_s1(rh[g+1]),
			.c_s1(ch[g+1]), .d_s1(dh[g+1])
		);
	end

	// Output stage: swap halves and apply the final permutation.
	logic vld_q;
	blk_t cipher_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld[Rounds];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cipher_q <= perm_fp({rh[Rounds], lh[Rounds]});
		end
	end

	assign out_ch.valid = vld_q;
	assign out_ch.cipher_block = cipher_q;
	assign out_ch.plain_block = '0;
	assign out_ch.cipher_key = '0;

`ifndef SYNTH
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.cipher_block))
		else $error("output word changed under stall");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("input stalled with empty output");
	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !vld[Rounds] |=> !out_ch.valid)
		else $error("output word invented");
`endif
endmodule
`default_nettype wire

@@ rtl/des_round.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One Feistel round with its key schedule step, registered at the output.
module des_round #(
	parameter int unsigned RoundIdx = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic vld,
	input  wire des_pkg::half_blk_t l,
	input  wire des_pkg::half_blk_t r,
	input  wire des_pkg::half_key_t c,
	input  wire des_pkg::half_key_t d,
	output logic vld_s1,
	output des_pkg::half_blk_t l_s1,
	output des_pkg::half_blk_t r_s1,
	output des_pkg::half_key_t c_s1,
	output des_pkg::half_key_t d_s1
);
	import des_pkg::*;

	half_key_t c_n, d_n;
	half_blk_t f;

	assign c_n = rotl28(c, RotTwo[4'(15 - RoundIdx)]);
	assign d_n = rotl28(d, RotTwo[4'(15 - RoundIdx)]);
	assign f = feistel(r, perm_pc2({c_n, d_n}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s1 <= r;
			r_s1 <= l ^ f;
			c_s1 <= c_n;
			d_s1 <= d_n;
		end
	end
endmodule
`default_nettype wire
